// ----- rtl/core/ps2md_pkg.sv -----
`default_nettype none

package ps2md_pkg;

    // cursor coordinate width
    localparam int COORD_W = 16;

    // protocol bytes
    localparam logic [7:0] ACK_BYTE   = 8'hFA;
    localparam logic [7:0] SYNC_MASK  = 8'hC8;
    localparam logic [7:0] SYNC_VALUE = 8'h08;

    // header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_XSIGN  = 4;
    localparam int HDR_YSIGN  = 5;

    // mouse_mode codes
    localparam logic [1:0] MODE_STD   = 2'd0;
    localparam logic [1:0] MODE_WHEEL = 2'd1;
    localparam logic [1:0] MODE_FIVE  = 2'd2;
    // spare code, framed as standard three-byte
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // register indexes (word address)
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // register reset values
    localparam logic [1:0]  MODE_RST   = MODE_STD;
    localparam logic [15:0] WIDTH_RST  = 16'd1024;
    localparam logic [15:0] HEIGHT_RST = 16'd768;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] width;
        logic [15:0] height;
    } cfg_t;

    // a completed packet, handed from framer to cursor stage
    typedef struct packed {
        logic              fire;
        logic [7:0]        header;
        logic [7:0]        x;
        logic [7:0]        y;
        logic signed [8:0] scroll;
    } pkt_t;

endpackage

`default_nettype wire

// ----- rtl/core/ps2_mouse_packet_decoder_unit.sv -----
`default_nettype none

// Channel   Ports               Dir  Moves
// -------   -----------------   ---  ---------------------------------------
// input     s_valid/s_ready     in   one raw mouse byte per item
// result    m_valid/m_ready     out  one decoded packet item (deltas, cursor)
// config    psel..pready        in   APB, mode @0x0, width @0x4, height @0x8
//
// One byte per cycle sustained. A byte is held in the input register,
// then the framer and cursor clamp (one 18-bit add and compare per axis)
// write the result register. Reset clears phase, cursor and both valids and
// needs no clearing pass. Only a packet-ending byte waits on a stalled
// result; other bytes keep flowing while a result is held.

module ps2_mouse_packet_decoder_unit import ps2md_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_data_byte,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [8:0]         m_delta_x,
    output logic signed [9:0]         m_delta_y,
    output logic signed [8:0]         m_scroll,
    output logic                      m_left_button,
    output logic                      m_right_button,
    output logic                      m_middle_button,
    output logic        [COORD_W-1:0] m_cursor_x,
    output logic        [COORD_W-1:0] m_cursor_y,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    cfg_t cfg;
    pkt_t pkt;
    logic res_busy;

    ps2md_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ps2md_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .cfg         (cfg),
        .res_busy    (res_busy),
        .pkt         (pkt)
    );

    ps2md_cursor u_cursor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pkt             (pkt),
        .cfg             (cfg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_scroll        (m_scroll),
        .m_left_button   (m_left_button),
        .m_right_button  (m_right_button),
        .m_middle_button (m_middle_button),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .res_busy        (res_busy)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ps2md_regs.sv -----
`default_nettype none

module ps2md_regs import ps2md_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    logic [1:0]  mode_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MODE:   mode_reg   <= pwdata[1:0];
                REG_WIDTH:  width_reg  <= pwdata[15:0];
                REG_HEIGHT: height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_MODE:   prdata = {30'd0, mode_reg};
            REG_WIDTH:  prdata = {16'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.mode   = mode_reg;
    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ps2md_framer.sv -----
`default_nettype none

module ps2md_framer import ps2md_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire cfg_t       cfg,
    input  wire logic       res_busy,
    output pkt_t            pkt
);

    typedef enum logic [2:0] {
        PH_ACK,
        PH_HEAD,
        PH_X,
        PH_Y,
        PH_WHEEL
    } phase_t;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;

    logic wheel_mode;
    logic produces;
    logic advance;

    assign wheel_mode = (cfg.mode == MODE_WHEEL) || (cfg.mode == MODE_FIVE);

    // does the held byte complete a packet
    assign produces = in_valid_reg &&
                      (((phase_reg == PH_Y) && !wheel_mode) || (phase_reg == PH_WHEEL));

    // bytes that emit nothing never wait on the result side
    assign advance = in_valid_reg && (!produces || !res_busy);
    assign s_ready = !in_valid_reg || advance;

    // phase and byte capture
    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        unique case (phase_reg)
            PH_HEAD: begin
                if ((in_byte_reg & SYNC_MASK) == SYNC_VALUE) begin
                    header_next = in_byte_reg;
                    phase_next  = PH_X;
                end
            end
            PH_X: begin
                x_next     = in_byte_reg;
                phase_next = PH_Y;
            end
            PH_Y: begin
                y_next     = in_byte_reg;
                phase_next = wheel_mode ? PH_WHEEL : PH_HEAD;
            end
            PH_WHEEL: begin
                phase_next = PH_HEAD;
            end
            default: begin
                phase_next = (in_byte_reg == ACK_BYTE) ? PH_HEAD : PH_ACK;
            end
        endcase
    end

    // packet out; y comes straight from the byte when it is the last one
    always_comb begin
        pkt.fire   = advance && produces;
        pkt.header = header_reg;
        pkt.x      = x_reg;
        pkt.y      = (phase_reg == PH_Y) ? in_byte_reg : y_reg;
        if (phase_reg == PH_WHEEL)
            pkt.scroll = 9'sd0 - $signed({in_byte_reg[7], in_byte_reg});
        else
            pkt.scroll = 9'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_ACK;
            header_reg   <= 8'd0;
            x_reg        <= 8'd0;
            y_reg        <= 8'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                phase_reg  <= phase_next;
                header_reg <= header_next;
                x_reg      <= x_next;
                y_reg      <= y_next;
            end
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ps2md_cursor.sv -----
`default_nettype none

module ps2md_cursor import ps2md_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pkt_t                 pkt,
    input  wire cfg_t                 cfg,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic signed [8:0]         m_delta_x,
    output logic signed [9:0]         m_delta_y,
    output logic signed [8:0]         m_scroll,
    output logic                      m_left_button,
    output logic                      m_right_button,
    output logic                      m_middle_button,
    output logic        [COORD_W-1:0] m_cursor_x,
    output logic        [COORD_W-1:0] m_cursor_y,
    output logic                      res_busy
);

    localparam logic [16:0] COORD_MAX = 17'((1 << COORD_W) - 1);

    // pos + delta, clamped to [0, min(size-1, COORD_MAX)]; size 0 acts as 1
    function automatic logic [COORD_W-1:0] clamp_axis(
        input logic        [COORD_W-1:0] pos,
        input logic signed [9:0]         delta,
        input logic        [15:0]        size
    );
        logic        [16:0] lim;
        logic signed [17:0] v;
        if (size == 16'd0)
            lim = 17'd0;
        else
            lim = {1'b0, size - 16'd1};
        if (lim > COORD_MAX)
            lim = COORD_MAX;
        v = $signed({{(18 - COORD_W){1'b0}}, pos}) + $signed({{8{delta[9]}}, delta});
        if (v[17])
            clamp_axis = '0;
        else if (v[16:0] > lim)
            clamp_axis = lim[COORD_W-1:0];
        else
            clamp_axis = v[COORD_W-1:0];
    endfunction

    logic                      res_valid_reg;
    logic signed [8:0]         dx_reg;
    logic signed [9:0]         dy_reg;
    logic signed [8:0]         scroll_reg;
    logic        [2:0]         btn_reg;
    logic        [COORD_W-1:0] col_reg, col_next;
    logic        [COORD_W-1:0] row_reg, row_next;
    logic signed [8:0]         dx;
    logic signed [9:0]         dy;

    // motion decode
    assign dx = $signed({pkt.header[HDR_XSIGN], pkt.x});
    assign dy = 10'sd0 - $signed({{2{pkt.header[HDR_YSIGN]}}, pkt.y});

    assign col_next = clamp_axis(col_reg, {dx[8], dx}, cfg.width);
    assign row_next = clamp_axis(row_reg, dy, cfg.height);

    assign res_busy = res_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end else if (pkt.fire) begin
            res_valid_reg <= 1'b1;
            col_reg       <= col_next;
            row_reg       <= row_next;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
        if (pkt.fire) begin
            dx_reg     <= dx;
            dy_reg     <= dy;
            scroll_reg <= pkt.scroll;
            btn_reg    <= {pkt.header[HDR_MIDDLE], pkt.header[HDR_RIGHT],
                           pkt.header[HDR_LEFT]};
        end
    end

    assign m_valid         = res_valid_reg;
    assign m_delta_x       = dx_reg;
    assign m_delta_y       = dy_reg;
    assign m_scroll        = scroll_reg;
    assign m_left_button   = btn_reg[0];
    assign m_right_button  = btn_reg[1];
    assign m_middle_button = btn_reg[2];
    assign m_cursor_x      = col_reg;
    assign m_cursor_y      = row_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ps2md_checker.sv -----
`default_nettype none

module ps2md_checker import ps2md_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic signed [8:0]    m_delta_x,
    input wire logic signed [9:0]    m_delta_y,
    input wire logic signed [8:0]    m_scroll,
    input wire logic                 m_left_button,
    input wire logic                 m_right_button,
    input wire logic                 m_middle_button,
    input wire logic [COORD_W-1:0]   m_cursor_x,
    input wire logic [COORD_W-1:0]   m_cursor_y,
    input wire logic                 pready
);

    // a held result keeps its payload until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_delta_x) && $stable(m_delta_y)
            && $stable(m_scroll) && $stable(m_cursor_x) && $stable(m_cursor_y)
            && $stable(m_left_button) && $stable(m_right_button)
            && $stable(m_middle_button))
        else $error("result changed while stalled");

    // input only backs up behind a stalled result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a stalled result");

    // reset leaves both sides empty
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not empty after reset");

    // the cursor moves only when a result is loaded
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |=> $stable(m_cursor_x) && $stable(m_cursor_y) || m_valid)
        else $error("cursor changed without a result");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind ps2_mouse_packet_decoder_unit ps2md_checker u_ps2md_checker (.*);

`default_nettype wire

// ----- sim/ps2md_packet_checker.sv -----
`timescale 1ns / 1ps

// Watches the byte, result and register channels of the decoder, tracks the
// packet framing and cursor on its own, and compares every result item.
module ps2md_packet_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [8:0]         m_delta_x,
    input  logic signed [9:0]         m_delta_y,
    input  logic signed [8:0]         m_scroll,
    input  logic                      m_left_button,
    input  logic                      m_right_button,
    input  logic                      m_middle_button,
    input  logic [15:0]               m_cursor_x,
    input  logic [15:0]               m_cursor_y,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    input  logic                      pready,
    output int unsigned               packets_pending,
    output int                        mismatches
);
    import ps2md_pkg::*;

    typedef enum logic [2:0] {
        PH_ACK    = 3'd0,
        PH_HEADER = 3'd1,
        PH_X      = 3'd2,
        PH_Y      = 3'd3,
        PH_WHEEL  = 3'd4
    } frame_phase_e;

    typedef struct {
        logic signed [8:0]  dx;
        logic signed [9:0]  dy;
        logic signed [8:0]  scroll;
        logic               left;
        logic               right;
        logic               middle;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } decoded_packet_t;

    // register copies
    logic [1:0]         mode_reg;
    logic [15:0]        width_reg;
    logic [15:0]        height_reg;

    // framing and cursor state
    frame_phase_e       phase;
    logic [7:0]         hdr_byte;
    logic [7:0]         x_byte;
    logic [7:0]         y_byte;
    logic [COORD_W-1:0] cursor_col;
    logic [COORD_W-1:0] cursor_row;

    decoded_packet_t    packets_due[$];

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // move one axis and clamp to the screen; a zero size acts as one
    function automatic logic [COORD_W-1:0] move_axis(
        input logic [COORD_W-1:0] pos, input int delta, input logic [15:0] size);
        int bound;
        int v;
        bound = (size == 16'd0) ? 0 : int'(size) - 1;
        if (bound > (1 << COORD_W) - 1)
            bound = (1 << COORD_W) - 1;
        v = int'(pos) + delta;
        if (v < 0)
            v = 0;
        if (v > bound)
            v = bound;
        return v[COORD_W-1:0];
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        decoded_packet_t pkt;
        bit              done;
        int              wheel;
        int              dx;
        int              dy;
        done  = 1'b0;
        wheel = 0;
        case (phase)
            PH_HEADER: begin
                // bad headers are dropped, framing waits on
                if ((b & SYNC_MASK) == SYNC_VALUE) begin
                    hdr_byte = b;
                    phase    = PH_X;
                end
            end
            PH_X: begin
                x_byte = b;
                phase  = PH_Y;
            end
            PH_Y: begin
                // packet length is decided here
                y_byte = b;
                if (mode_reg == MODE_WHEEL || mode_reg == MODE_FIVE) begin
                    phase = PH_WHEEL;
                end else begin
                    phase = PH_HEADER;
                    done  = 1'b1;
                end
            end
            PH_WHEEL: begin
                wheel = -int'($signed(b));
                phase = PH_HEADER;
                done  = 1'b1;
            end
            default: phase = (b == ACK_BYTE) ? PH_HEADER : PH_ACK;
        endcase
        if (done) begin
            dx = int'(x_byte) - (hdr_byte[HDR_XSIGN] ? 256 : 0);
            dy = (hdr_byte[HDR_YSIGN] ? 256 : 0) - int'(y_byte);
            cursor_col = move_axis(cursor_col, dx, width_reg);
            cursor_row = move_axis(cursor_row, dy, height_reg);
            pkt.dx     = dx[8:0];
            pkt.dy     = dy[9:0];
            pkt.scroll = wheel[8:0];
            pkt.left   = hdr_byte[HDR_LEFT];
            pkt.right  = hdr_byte[HDR_RIGHT];
            pkt.middle = hdr_byte[HDR_MIDDLE];
            pkt.col    = cursor_col;
            pkt.row    = cursor_row;
            packets_due.push_back(pkt);
        end
    endtask

    task automatic check_packet();
        decoded_packet_t want;
        if (packets_due.size() == 0) begin
            flag_error("result item with no packet expected");
        end else begin
            want = packets_due.pop_front();
            check_field("delta_x", int'(m_delta_x), int'(want.dx));
            check_field("delta_y", int'(m_delta_y), int'(want.dy));
            check_field("scroll", int'(m_scroll), int'(want.scroll));
            check_field("left_button", int'(m_left_button), int'(want.left));
            check_field("right_button", int'(m_right_button), int'(want.right));
            check_field("middle_button", int'(m_middle_button), int'(want.middle));
            check_field("cursor_x", int'(m_cursor_x), int'(want.col));
            check_field("cursor_y", int'(m_cursor_y), int'(want.row));
        end
    endtask

    // register writes, then byte items, then result items, all at one edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   = MODE_RST;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            phase      = PH_ACK;
            hdr_byte   = 8'd0;
            x_byte     = 8'd0;
            y_byte     = 8'd0;
            cursor_col = '0;
            cursor_row = '0;
            mismatches = 0;
            packets_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MODE:   mode_reg   = pwdata[1:0];
                    REG_WIDTH:  width_reg  = pwdata[15:0];
                    REG_HEIGHT: height_reg = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                decode_byte(s_data_byte);
            if (m_valid && m_ready)
                check_packet();
        end
        packets_pending <= packets_due.size();
    end

endmodule

// ----- sim/tb_ps2_mouse_packet_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder_unit;
    import ps2md_pkg::*;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic [7:0]          s_data_byte = 8'd0;
    logic                m_ready     = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [3:0]          paddr       = 4'd0;
    logic [31:0]         pwdata      = 32'd0;

    logic                s_ready;
    logic                m_valid;
    logic signed [8:0]   m_delta_x;
    logic signed [9:0]   m_delta_y;
    logic signed [8:0]   m_scroll;
    logic                m_left_button;
    logic                m_right_button;
    logic                m_middle_button;
    logic [COORD_W-1:0]  m_cursor_x;
    logic [COORD_W-1:0]  m_cursor_y;
    logic [31:0]         prdata;
    logic                pready;

    int unsigned         packets_pending;
    int                  mismatches;

    // stimulus shaping
    bit                  steady      = 1'b0;
    int                  bytes_sent  = 0;
    logic [1:0]          framing_mode = MODE_STD;

    ps2_mouse_packet_decoder_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_scroll        (m_scroll),
        .m_left_button   (m_left_button),
        .m_right_button  (m_right_button),
        .m_middle_button (m_middle_button),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    ps2md_packet_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delta_x       (m_delta_x),
        .m_delta_y       (m_delta_y),
        .m_scroll        (m_scroll),
        .m_left_button   (m_left_button),
        .m_right_button  (m_right_button),
        .m_middle_button (m_middle_button),
        .m_cursor_x      (m_cursor_x),
        .m_cursor_y      (m_cursor_y),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .packets_pending (packets_pending),
        .mismatches      (mismatches)
    );

    // 100 MHz clock
    always begin
        #5;
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // motion and wheel bytes, corners weighted
    function automatic logic [7:0] pick_motion();
        logic [7:0] corners [6];
        corners = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // stop sending, wait out pending packets and the pipeline
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (packets_pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_screen(input logic [1:0] mode, input logic [15:0] w,
                              input logic [15:0] h);
        drain();
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        framing_mode = mode;
    endtask

    task automatic send_packet();
        logic [7:0] hdr;
        hdr = (8'($urandom) & ~SYNC_MASK) | SYNC_VALUE;
        send_byte(hdr);
        send_byte(pick_motion());
        send_byte(pick_motion());
        if (framing_mode == MODE_WHEEL || framing_mode == MODE_FIVE)
            send_byte(pick_motion());
    endtask

    // mostly clean packets, some noise and cut-off packets
    task automatic random_stretch(input int budget);
        int start;
        int roll;
        start  = bytes_sent;
        steady = 1'b1;
        while (bytes_sent < start + budget) begin
            if (bytes_sent - start >= 40)
                steady = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                send_packet();
            end else if (roll < 95) begin
                send_byte(8'($urandom));
            end else begin
                send_byte((8'($urandom) & ~SYNC_MASK) | SYNC_VALUE);
                send_byte(pick_motion());
            end
        end
        steady = 1'b0;
    endtask

    // result side back-pressure
    initial begin : result_backpressure
        int run;
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] opening [22];
        opening = '{8'h08, 8'hFF, 8'h00, ACK_BYTE,  // dropped until the ack
                    ACK_BYTE, 8'h37, 8'hC8,         // fail the sync test
                    8'h09, 8'h00, 8'h00,            // left, no motion
                    8'h0F, 8'hFF, 8'h80,            // all buttons, +255 / up 128
                    8'h38, 8'h00, 8'h00,            // both signs, -256 / down 256
                    8'h3C, 8'hFF, 8'hFF,            // -1 / down 1
                    8'h0A, 8'h7F, 8'h01};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings
        foreach (opening[k])
            send_byte(opening[k]);

        // mode is taken at the third byte: a pending wheel byte survives
        drain();
        write_reg(REG_MODE, 32'(MODE_WHEEL));
        send_byte(8'h19);
        send_byte(8'h05);
        send_byte(8'hF0);
        drain();
        write_reg(REG_MODE, 32'(MODE_STD));
        send_byte(8'h80);
        // and a switch before the third byte lengthens the packet
        send_byte(8'h0C);
        send_byte(8'h10);
        drain();
        write_reg(REG_MODE, 32'(MODE_WHEEL));
        send_byte(8'h20);
        send_byte(8'h7F);
        framing_mode = MODE_WHEEL;

        set_screen(MODE_WHEEL, 16'hFFFF, 16'hFFFF);
        random_stretch(160);
        // shrunk screen: cursor is pulled in at the next packet
        set_screen(MODE_FIVE, 16'd1, 16'd1);
        random_stretch(150);
        // unused mode code and zero sizes
        set_screen(MODE_SPARE, 16'd0, 16'd0);
        random_stretch(150);
        set_screen(MODE_WHEEL, 16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
        random_stretch(160);
        set_screen(MODE_STD, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        random_stretch(160);
        set_screen(MODE_FIVE, 16'd640, 16'd480);
        random_stretch(160);

        drain();
        if (mismatches == 0)
            $display("ps2_mouse_packet_decoder_unit regression: pass");
        else
            $display("ps2_mouse_packet_decoder_unit regression: fail");
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("ps2_mouse_packet_decoder_unit regression: fail");
        $finish;
    end

endmodule
